// ===== design/cdu_pkg.sv =====
// Shared types, constants and calendar helper functions for the calendar date unit.
package cdu_pkg;

   localparam int unsigned MIN_YEAR = 1950;
   localparam int unsigned MAX_YEAR = 2049;
   // days from 1 Jan MIN_YEAR to 31 Dec MAX_YEAR
   localparam logic [15:0] MAX_IDX = 16'd36524;

   localparam logic [2:0] ACT_LOAD    = 3'd0;
   localparam logic [2:0] ACT_NEXT    = 3'd1;
   localparam logic [2:0] ACT_PREV    = 3'd2;
   localparam logic [2:0] ACT_PLUS7   = 3'd3;
   localparam logic [2:0] ACT_MINUS7  = 3'd4;
   localparam logic [2:0] ACT_OFFSET  = 3'd5;
   localparam logic [2:0] ACT_COMPARE = 3'd6;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_DOMAIN   = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   localparam logic [1:0] ORD_EARLIER = 2'd0;
   localparam logic [1:0] ORD_EQUAL   = 2'd1;
   localparam logic [1:0] ORD_LATER   = 2'd2;

   // weekday codes inside the datapath: 0 Monday .. 6 Sunday
   localparam logic [2:0] WD_JAN1_FIRST = 3'd6;   // 1 Jan MIN_YEAR is a Sunday
   localparam logic [2:0] WD_JAN1_PRIOR = 3'd5;   // 1 Jan of the year before

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_EVAL, S_RESOLVE, S_WALK_YEAR, S_WALK_MONTH, S_WEEK, S_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic eval;
      logic resolve;
      logic year;
      logic month;
      logic week;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
      logic out_free;
   } sts_type;

   function automatic logic [8:0] cum_days(input logic [3:0] m);
      logic [8:0] r;
      unique case (m)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] r;
      unique case (m)
         4'd2:                      r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
         default:                   r = 5'd31;
      endcase
      return r;
   endfunction

   // remainder by seven for small values
   function automatic logic [2:0] mod7(input logic [5:0] x);
      logic [11:0] p;
      logic [5:0]  r;
      p = 12'(x) * 12'd37;
      r = x - 6'(p[11:8]) * 6'd7;
      return r[2:0];
   endfunction

   function automatic logic [5:0] weeks_in(input logic [2:0] jan1_wd, input logic leap);
      return ((jan1_wd == 3'd3) || ((jan1_wd == 3'd2) && leap)) ? 6'd53 : 6'd52;
   endfunction

endpackage

// ===== design/calendar_date_unit.sv =====
// Calendar date unit: holds one date from 1950 to 2049 and runs date actions on it.
//
// Request channel (req_*): one item per action: load, step by one or seven days,
// add a signed day offset, or compare against a given date. Result channel
// (rsp_*): one item per request with the resulting date, weekday, ISO week,
// day difference, order and status. Both channels use valid/ready.
// Each item passes through prep, eval and resolve, then the calendar walk: one
// step per year past 1950 and one per month of the target date, then the week
// step and the emit. The year walk takes the most steps. One item is in work
// at a time; req_ready is high only while the unit is idle.
// The result sits in an output register, so the next request is taken while
// a result still waits; if the receiver stalls, the following result holds
// in the last step until the output register frees up.
// Reset (synchronous, active high) sets the stored date to 1 January 1950
// and clears both channels.
module calendar_date_unit import cdu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [4:0]         req_in_day,
   input  logic [3:0]         req_in_month,
   input  logic [13:0]        req_in_year,
   input  logic signed [16:0] req_day_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_out_day,
   output logic [3:0]         rsp_out_month,
   output logic [11:0]        rsp_out_year,
   output logic [2:0]         rsp_weekday,
   output logic [5:0]         rsp_week_number,
   output logic [15:0]        rsp_day_difference,
   output logic [1:0]         rsp_order,
   output logic [1:0]         rsp_status
);

   cmd_type cmd;
   sts_type sts;

   cdu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdu_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_in_day         (req_in_day),
      .req_in_month       (req_in_month),
      .req_in_year        (req_in_year),
      .req_day_offset     (req_day_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_day        (rsp_out_day),
      .rsp_out_month      (rsp_out_month),
      .rsp_out_year       (rsp_out_year),
      .rsp_weekday        (rsp_weekday),
      .rsp_week_number    (rsp_week_number),
      .rsp_day_difference (rsp_day_difference),
      .rsp_order          (rsp_order),
      .rsp_status         (rsp_status)
   );

endmodule

// ===== design/cdu_ctrl.sv =====
// Sequencer for the calendar date unit: steps each item through its phases.
module cdu_ctrl import cdu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (req_valid) state_in = S_PREP;
         S_PREP:       state_in = S_EVAL;
         S_EVAL:       state_in = S_RESOLVE;
         S_RESOLVE:    state_in = S_WALK_YEAR;
         S_WALK_YEAR:  if (sts.year_done) state_in = S_WALK_MONTH;
         S_WALK_MONTH: if (sts.month_done) state_in = S_WEEK;
         S_WEEK:       state_in = S_EMIT;
         S_EMIT:       if (sts.out_free) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_PREP:       cmd.prep    = 1'b1;
         S_EVAL:       cmd.eval    = 1'b1;
         S_RESOLVE:    cmd.resolve = 1'b1;
         S_WALK_YEAR:  cmd.year    = 1'b1;
         S_WALK_MONTH: cmd.month   = !sts.month_done;
         S_WEEK:       cmd.week    = 1'b1;
         S_EMIT:       cmd.emit    = sts.out_free;
         default:      cmd         = '0;
      endcase
   end

endmodule

// ===== design/cdu_datapath.sv =====
// Datapath of the calendar date unit: validation, day index math and date walk.
module cdu_datapath import cdu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [2:0]         req_action,
   input  logic [4:0]         req_in_day,
   input  logic [3:0]         req_in_month,
   input  logic [13:0]        req_in_year,
   input  logic signed [16:0] req_day_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_out_day,
   output logic [3:0]         rsp_out_month,
   output logic [11:0]        rsp_out_year,
   output logic [2:0]         rsp_weekday,
   output logic [5:0]         rsp_week_number,
   output logic [15:0]        rsp_day_difference,
   output logic [1:0]         rsp_order,
   output logic [1:0]         rsp_status
);

   // captured item
   logic [2:0]         action_ff;
   logic [4:0]         day_ff;
   logic [3:0]         month_ff;
   logic [13:0]        year_ff;
   logic signed [16:0] offset_ff;
   // prep / eval results
   logic [13:0] wyear_ff;
   logic [7:0]  q100_ff;
   logic [1:0]  vstat_ff;
   logic [15:0] gidx_ff;
   // resolve results
   logic [15:0] t_ff;
   logic        store_ff;
   logic [1:0]  status_ff;
   logic [15:0] diff_ff;
   logic [1:0]  order_ff;
   // stored date as a day index from 1 Jan MIN_YEAR
   logic [15:0] stored_idx_ff;
   // walk state
   logic [15:0] rem_ff;
   logic [6:0]  yo_ff;
   logic [2:0]  jan_wd_ff, prev_wd_ff;
   logic        prev_leap_ff;
   logic [3:0]  mm_ff;
   logic [2:0]  mwd_ff;
   logic [8:0]  doy_ff;
   logic [2:0]  wd_ff;
   logic [8:0]  x_ff;
   // outputs
   logic        rsp_valid_ff;
   logic [4:0]  out_day_ff;
   logic [3:0]  out_month_ff;
   logic [11:0] out_year_ff;
   logic [2:0]  weekday_ff;
   logic [5:0]  week_ff;
   logic [15:0] out_diff_ff;
   logic [1:0]  out_order_ff;
   logic [1:0]  out_status_ff;

   // prep: widen the year and estimate year / 100
   logic [13:0] wyear;
   logic [26:0] q_prod;
   always_comb begin
      if (year_ff <= 14'd49) begin
         wyear = year_ff + 14'd2000;
      end else if (year_ff <= 14'd99) begin
         wyear = year_ff + 14'd1900;
      end else begin
         wyear = year_ff;
      end
      q_prod = 27'(wyear) * 27'd5243;
   end

   // eval: validate and convert the given date to an index
   logic        gleap;
   logic [14:0] cent;
   logic [4:0]  gmlen;
   logic [1:0]  vstat;
   logic [13:0] yo_full;
   logic [6:0]  gyo;
   logic [15:0] gidx;
   always_comb begin
      cent  = 15'(q100_ff) * 15'd100;
      gleap = (wyear_ff[1:0] == 2'b00) &&
              ((cent != {1'b0, wyear_ff}) || (q100_ff[1:0] == 2'b00));
      gmlen = month_len(month_ff, gleap);
      priority if (day_ff == 5'd0 || month_ff == 4'd0 || month_ff > 4'd12) begin
         vstat = ST_INVALID;
      end else if (wyear_ff < 14'd1000 || wyear_ff > 14'd9999 || day_ff > gmlen) begin
         vstat = ST_DOMAIN;
      end else if (wyear_ff < 14'(MIN_YEAR) || wyear_ff > 14'(MAX_YEAR)) begin
         vstat = ST_RANGE;
      end else begin
         vstat = ST_OK;
      end
      yo_full = wyear_ff - 14'(MIN_YEAR);
      gyo     = yo_full[6:0];
      gidx    = 16'(gyo) * 16'd365 + 16'((8'(gyo) + 8'd1) >> 2) + 16'(cum_days(month_ff))
                + 16'(day_ff) - 16'd1 + 16'((month_ff > 4'd2) && (wyear_ff[1:0] == 2'b00));
   end

   // resolve: pick the target index
   logic signed [17:0] cur_s, step_sum, off_sum;
   logic signed [16:0] dd;
   logic [15:0] t;
   logic        store;
   logic [1:0]  status;
   logic [15:0] diff;
   logic [1:0]  order;
   always_comb begin
      cur_s    = $signed({2'b00, stored_idx_ff});
      off_sum  = cur_s + 18'(offset_ff);
      dd       = $signed({1'b0, stored_idx_ff}) - $signed({1'b0, gidx_ff});
      unique case (action_ff)
         ACT_NEXT:   step_sum = cur_s + 18'sd1;
         ACT_PREV:   step_sum = cur_s - 18'sd1;
         ACT_PLUS7:  step_sum = cur_s + 18'sd7;
         default:    step_sum = cur_s - 18'sd7;
      endcase
      t      = stored_idx_ff;
      store  = 1'b0;
      status = ST_OK;
      diff   = 16'd0;
      order  = ORD_EARLIER;
      unique case (action_ff)
         ACT_LOAD: begin
            status = vstat_ff;
            if (vstat_ff == ST_OK) begin
               t     = gidx_ff;
               store = 1'b1;
            end
         end
         ACT_NEXT, ACT_PREV, ACT_PLUS7, ACT_MINUS7: begin
            if (step_sum < 18'sd0 || step_sum > $signed({2'b00, MAX_IDX})) begin
               status = ST_RANGE;
            end else begin
               t     = step_sum[15:0];
               store = 1'b1;
            end
         end
         ACT_OFFSET: begin
            priority if (off_sum < 18'sd0) begin
               t = 16'd0;
            end else if (off_sum > $signed({2'b00, MAX_IDX})) begin
               t = MAX_IDX;
            end else begin
               t = off_sum[15:0];
            end
         end
         ACT_COMPARE: begin
            status = vstat_ff;
            if (vstat_ff == ST_OK) begin
               diff = dd[16] ? 16'(-dd) : dd[15:0];
               if (dd[16]) begin
                  order = ORD_EARLIER;
               end else if (dd == 17'sd0) begin
                  order = ORD_EQUAL;
               end else begin
                  order = ORD_LATER;
               end
            end
         end
         default: t = stored_idx_ff;
      endcase
   end

   // walk: years first, then months
   logic       yleap;
   logic [8:0] ylen;
   logic [4:0] mlen;
   always_comb begin
      yleap = (yo_ff[1:0] == 2'd2);
      ylen  = yleap ? 9'd366 : 9'd365;
      mlen  = month_len(mm_ff, yleap);
      sts.year_done  = rem_ff < 16'(ylen);
      sts.month_done = (mm_ff == 4'd12) || (rem_ff < 16'(mlen));
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // week number
   logic [22:0] w_prod;
   logic [6:0]  w;
   logic [5:0]  wk_this, wk_prev, week;
   always_comb begin
      w_prod  = 23'(x_ff) * 23'd9363;
      w       = w_prod[22:16];
      wk_this = weeks_in(jan_wd_ff, yleap);
      wk_prev = weeks_in(prev_wd_ff, prev_leap_ff);
      priority if (w == 7'd0) begin
         week = wk_prev;
      end else if (w > 7'(wk_this)) begin
         week = 6'd1;
      end else begin
         week = w[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         day_ff    <= req_in_day;
         month_ff  <= req_in_month;
         year_ff   <= req_in_year;
         offset_ff <= req_day_offset;
      end
      if (cmd.prep) begin
         wyear_ff <= wyear;
         q100_ff  <= q_prod[26:19];
      end
      if (cmd.eval) begin
         vstat_ff <= vstat;
         gidx_ff  <= gidx;
      end
      if (cmd.resolve) begin
         t_ff         <= t;
         store_ff     <= store;
         status_ff    <= status;
         diff_ff      <= diff;
         order_ff     <= order;
         rem_ff       <= t;
         yo_ff        <= 7'd0;
         jan_wd_ff    <= WD_JAN1_FIRST;
         prev_wd_ff   <= WD_JAN1_PRIOR;
         prev_leap_ff <= 1'b0;
      end
      if (cmd.year) begin
         if (!sts.year_done) begin
            rem_ff       <= rem_ff - 16'(ylen);
            yo_ff        <= yo_ff + 7'd1;
            prev_wd_ff   <= jan_wd_ff;
            prev_leap_ff <= yleap;
            jan_wd_ff    <= mod7(6'(jan_wd_ff) + 6'd1 + 6'(yleap));
         end else begin
            mm_ff  <= 4'd1;
            mwd_ff <= jan_wd_ff;
            doy_ff <= rem_ff[8:0];
         end
      end
      if (cmd.month) begin
         rem_ff <= rem_ff - 16'(mlen);
         mm_ff  <= mm_ff + 4'd1;
         mwd_ff <= mod7(6'(mwd_ff) + 6'(mod7(6'(mlen))));
      end
      if (cmd.week) begin
         wd_ff <= mod7(6'(mwd_ff) + rem_ff[5:0]);
         x_ff  <= doy_ff - 9'(mod7(6'(mwd_ff) + rem_ff[5:0])) + 9'd10;
      end
      if (cmd.emit) begin
         out_day_ff    <= rem_ff[4:0] + 5'd1;
         out_month_ff  <= mm_ff;
         out_year_ff   <= 12'(MIN_YEAR) + 12'(yo_ff);
         weekday_ff    <= wd_ff + 3'd1;
         week_ff       <= week;
         out_diff_ff   <= diff_ff;
         out_order_ff  <= order_ff;
         out_status_ff <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         stored_idx_ff <= 16'd0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.emit && store_ff) begin
            stored_idx_ff <= t_ff;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_day        = out_day_ff;
   assign rsp_out_month      = out_month_ff;
   assign rsp_out_year       = out_year_ff;
   assign rsp_weekday        = weekday_ff;
   assign rsp_week_number    = week_ff;
   assign rsp_day_difference = out_diff_ff;
   assign rsp_order          = out_order_ff;
   assign rsp_status         = out_status_ff;

endmodule

// ===== tb/calendar_date_checker.sv =====
// Checker for the calendar date unit: predicts each result and compares it on the result channel.
module calendar_date_checker import cdu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [4:0]         req_in_day,
   input  logic [3:0]         req_in_month,
   input  logic [13:0]        req_in_year,
   input  logic signed [16:0] req_day_offset,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [4:0]         rsp_out_day,
   input  logic [3:0]         rsp_out_month,
   input  logic [11:0]        rsp_out_year,
   input  logic [2:0]         rsp_weekday,
   input  logic [5:0]         rsp_week_number,
   input  logic [15:0]        rsp_day_difference,
   input  logic [1:0]         rsp_order,
   input  logic [1:0]         rsp_status,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic [4:0]  dd;
      logic [3:0]  mm;
      logic [11:0] yy;
      logic [2:0]  wd;
      logic [5:0]  wk;
      logic [15:0] diff;
      logic [1:0]  ord;
      logic [1:0]  st;
   } date_result_type;

   date_result_type expected_dates[$];
   int held_day, held_month, held_year;

   function automatic bit leap_year(int y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   function automatic int days_in_month(int m, int y);
      int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m < 1 || m > 12) return 31;
      if (m == 2 && leap_year(y)) return 29;
      return lens[m - 1];
   endfunction

   // serial day number, 1 for 1 January of year 1
   function automatic longint serial_day(int d, int m, int y);
      int cum[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      longint p, n;
      int mi;
      p = (y > 0) ? y - 1 : 0;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      mi = (m >= 1 && m <= 12) ? m - 1 : 0;
      n += cum[mi] + d;
      if (mi >= 2 && leap_year(y)) n += 1;
      return n;
   endfunction

   function automatic void serial_to_date(longint n, output int d, output int m, output int y);
      y = MIN_YEAR;
      m = 1;
      while (y < MAX_YEAR && serial_day(1, 1, y + 1) <= n) y++;
      n -= serial_day(1, 1, y) - 1;
      while (m < 12 && n > days_in_month(m, y)) begin
         n -= days_in_month(m, y);
         m++;
      end
      d = int'(n);
   endfunction

   function automatic int day_of_week(longint n);
      int r;
      r = int'(n % 7);
      return (r == 0) ? 7 : r;
   endfunction

   function automatic int weeks_of_year(int y);
      int j;
      j = day_of_week(serial_day(1, 1, y));
      return (j == 4 || (j == 3 && leap_year(y))) ? 53 : 52;
   endfunction

   function automatic int iso_week_of(int d, int m, int y);
      longint n, w;
      n = serial_day(d, m, y);
      w = (n - serial_day(1, 1, y) + 1 - day_of_week(n) + 10) / 7;
      if (w < 1) return weeks_of_year(y - 1);
      if (w > weeks_of_year(y)) return 1;
      return int'(w);
   endfunction

   // widen a two-digit year, then validate in the block's order
   function automatic logic [1:0] validate_date(int d, int m, inout int y);
      if (y <= 99) y = (y <= 49) ? 2000 + y : 1900 + y;
      if (d == 0 || d > 31 || m == 0 || m > 12) return ST_INVALID;
      if (y < 1000 || y > 9999) return ST_DOMAIN;
      if (d > days_in_month(m, y)) return ST_DOMAIN;
      if (y < MIN_YEAR || y > MAX_YEAR) return ST_RANGE;
      return ST_OK;
   endfunction

   function automatic date_result_type predict_date(logic [2:0] act, int gd, int gm, int gy,
                                                    int off);
      date_result_type r;
      longint lo, hi, cur, t, dd;
      int rd, rm, ry;
      lo = serial_day(1, 1, MIN_YEAR);
      hi = serial_day(31, 12, MAX_YEAR);
      cur = serial_day(held_day, held_month, held_year);
      rd = held_day; rm = held_month; ry = held_year;
      r = '0;
      case (act)
         ACT_LOAD: begin
            r.st = validate_date(gd, gm, gy);
            if (r.st == ST_OK) begin
               held_day = gd; held_month = gm; held_year = gy;
               rd = gd; rm = gm; ry = gy;
            end
         end
         ACT_NEXT, ACT_PREV, ACT_PLUS7, ACT_MINUS7: begin
            t = cur + ((act == ACT_NEXT) ? 1 : (act == ACT_PREV) ? -1 :
                       (act == ACT_PLUS7) ? 7 : -7);
            if (t < lo || t > hi) r.st = ST_RANGE;
            else begin
               serial_to_date(t, rd, rm, ry);
               held_day = rd; held_month = rm; held_year = ry;
            end
         end
         ACT_OFFSET: begin
            t = cur + off;
            if (t < lo) t = lo;
            if (t > hi) t = hi;
            serial_to_date(t, rd, rm, ry);
         end
         ACT_COMPARE: begin
            r.st = validate_date(gd, gm, gy);
            if (r.st == ST_OK) begin
               dd = cur - serial_day(gd, gm, gy);
               r.diff = 16'((dd < 0) ? -dd : dd);
               r.ord = (dd < 0) ? ORD_EARLIER : (dd == 0) ? ORD_EQUAL : ORD_LATER;
            end
         end
         default: ;
      endcase
      r.dd = 5'(rd); r.mm = 4'(rm); r.yy = 12'(ry);
      r.wd = 3'(day_of_week(serial_day(rd, rm, ry)));
      r.wk = 6'(iso_week_of(rd, rm, ry));
      return r;
   endfunction

   assign pending_count = expected_dates.size();

   always @(posedge clock) begin
      date_result_type seen, want;
      if (reset) begin
         held_day = 1;
         held_month = 1;
         held_year = MIN_YEAR;
         fail_count <= 0;
         expected_dates.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_out_day, rsp_out_month, rsp_out_year, rsp_weekday,
                     rsp_week_number, rsp_day_difference, rsp_order, rsp_status};
            if (expected_dates.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", seen);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_dates.pop_front();
               if (seen !== want) begin
                  if (fail_count < 10) $display("mismatch: expected %p actual %p", want, seen);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // predict with blocking state update so back-to-back items chain correctly
         if (req_valid && req_ready)
            expected_dates.push_back(predict_date(req_action, req_in_day, req_in_month,
                                                  req_in_year, int'(req_day_offset)));
      end
   end

endmodule

// ===== tb/calendar_date_unit_test.sv =====
// Testbench top for the calendar date unit: drives actions and gives the verdict.
module calendar_date_unit_test;
   import cdu_pkg::*;

   logic               clock, reset;
   logic               req_valid, req_ready, rsp_valid, rsp_ready;
   logic [2:0]         req_action;
   logic [4:0]         req_in_day;
   logic [3:0]         req_in_month;
   logic [13:0]        req_in_year;
   logic signed [16:0] req_day_offset;
   logic [4:0]         rsp_out_day;
   logic [3:0]         rsp_out_month;
   logic [11:0]        rsp_out_year;
   logic [2:0]         rsp_weekday;
   logic [5:0]         rsp_week_number;
   logic [15:0]        rsp_day_difference;
   logic [1:0]         rsp_order, rsp_status;
   int                 fail_count, pending_count;
   bit                 calm_phase;

   calendar_date_unit dut (.*);
   calendar_date_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver stalls in bursts
   initial begin
      int gap;
      rsp_ready = 0;
      @(posedge clock);
      forever begin
         rsp_ready <= 1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!calm_phase && $urandom_range(0, 1)) begin
            gap = $urandom_range(1, 19);
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic send_item(logic [2:0] act, int d, int m, int y, int off);
      req_valid <= 1;
      req_action <= act;
      req_in_day <= 5'(d);
      req_in_month <= 4'(m);
      req_in_year <= 14'(y);
      req_day_offset <= 17'(off);
      do @(posedge clock); while (!req_ready);
      if (calm_phase || $urandom_range(0, 3) != 0) return;
      req_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clock);
   endtask

   task automatic send_random;
      int pick, act, d, m, y;
      pick = $urandom_range(0, 99);
      act = $urandom_range(0, 7);
      d = $urandom_range(1, 28);
      m = $urandom_range(1, 12);
      y = $urandom_range(MIN_YEAR, MAX_YEAR);
      if (pick < 10) begin
         d = $urandom_range(0, 31);
         m = $urandom_range(0, 15);
         y = $urandom_range(0, 16383);
      end else if (pick < 20) y = $urandom_range(0, 99);
      else if (pick < 25) y = $urandom_range(1000, 9999);
      else if (pick < 30) d = $urandom_range(29, 31);
      send_item(3'(act), d, m, y, $urandom_range(0, 2 * 36524) - 36524 -
                (($urandom_range(0, 9) == 0) ? 0 : 0));
      // raw offset bits, including values beyond the range
      if (pick == 99) send_item(ACT_OFFSET, 0, 0, 0, $urandom_range(0, 131071));
   endtask

   initial begin
      req_valid = 0;
      req_action = ACT_LOAD;
      req_in_day = 0;
      req_in_month = 0;
      req_in_year = 0;
      req_day_offset = 0;
      calm_phase = 0;
      reset = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: range ends, widening, validation order, all actions
      send_item(ACT_PREV, 1, 1, 1950, 0);
      send_item(ACT_MINUS7, 1, 1, 1950, 0);
      send_item(ACT_LOAD, 31, 12, 2049, 0);
      send_item(ACT_NEXT, 0, 0, 0, 0);
      send_item(ACT_PLUS7, 0, 0, 0, 0);
      send_item(ACT_OFFSET, 0, 0, 0, -36524);
      send_item(ACT_OFFSET, 0, 0, 0, 36524);
      send_item(ACT_OFFSET, 0, 0, 0, -65536);
      send_item(ACT_OFFSET, 0, 0, 0, 65535);
      send_item(ACT_LOAD, 29, 2, 0, 0);
      send_item(ACT_LOAD, 29, 2, 49, 0);
      send_item(ACT_LOAD, 1, 1, 50, 0);
      send_item(ACT_LOAD, 1, 1, 5, 0);
      send_item(ACT_LOAD, 0, 1, 2000, 0);
      send_item(ACT_LOAD, 31, 15, 16383, 0);
      send_item(ACT_LOAD, 31, 4, 999, 0);
      send_item(ACT_LOAD, 1, 1, 10000, 0);
      send_item(ACT_LOAD, 31, 12, 9999, 0);
      send_item(ACT_LOAD, 29, 2, 1900, 0);
      send_item(ACT_COMPARE, 31, 12, 2049, 0);
      send_item(ACT_COMPARE, 1, 1, 1950, 0);
      send_item(ACT_COMPARE, 0, 13, 2000, 0);
      send_item(3'd7, 31, 15, 16383, -1);
      send_item(ACT_NEXT, 0, 0, 0, 0);
      send_item(ACT_PREV, 0, 0, 0, 0);
      req_valid <= 0;
      // pause until every expected result is back
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      for (int i = 0; i < 900; i++) begin
         if (i == 800) calm_phase = 1;
         send_random();
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
